// ----- src/sled_pkg.sv -----
`timescale 1ns / 1ps
package sled_pkg;

	typedef enum logic [7:0] {
		M_IDLE = 8'b0000_0001,
		M_BODY = 8'b0000_0010,
		M_ESC  = 8'b0000_0100,
		M_HEX  = 8'b0000_1000,
		M_DEC  = 8'b0001_0000,
		M_OCT  = 8'b0010_0000,
		M_SKIP = 8'b0100_0000,
		M_PASS = 8'b1000_0000
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_O      = 8'h6F;

	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_VT  = 8'h0B;
	localparam logic [7:0] CTL_ESC = 8'h1B;
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_NUL = 8'h00;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       literal_done;
		logic       unterminated;
	} res_t;

	typedef struct packed {
		logic two;
		res_t first;
		res_t second;
	} ent_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} digit_t;

	function automatic logic [1:0] trail_count(input logic [7:0] b);
		logic [1:0] t;
		t = 2'd0;
		if (b[7:5] == 3'b110) t = 2'd1;
		else if (b[7:4] == 4'b1110) t = 2'd2;
		else if (b[7:3] == 5'b11110) t = 2'd3;
		return t;
	endfunction

	function automatic digit_t digit_of(input mode_t m, input logic [7:0] b);
		digit_t d;
		d.ok = 1'b0;
		d.value = b[3:0];
		if (b >= 8'h30 && b <= 8'h39) begin
			d.value = b[3:0];
			d.ok = (m == M_HEX) || (m == M_DEC) || (b <= 8'h37);
		end else if (m == M_HEX && ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))) begin
			d.ok = 1'b1;
			d.value = b[3:0] + 4'd9;
		end
		return d;
	endfunction

endpackage

// ----- src/sled_if.sv -----
`timescale 1ns / 1ps
interface sled_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_open;
	logic       source_end;

	modport source(output valid, in_byte, is_open, source_end, input ready);
	modport sink(input valid, in_byte, is_open, source_end, output ready);
endinterface

interface sled_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       literal_done;
	logic       unterminated;
	logic       run_last;

	modport source(output valid, out_byte, literal_done, unterminated, run_last, input ready);
	modport sink(input valid, out_byte, literal_done, unterminated, run_last, output ready);
endinterface

// ----- src/sled_front.sv -----
`timescale 1ns / 1ps
module sled_front (
	input  logic          clk,
	input  logic          arst_n,
	sled_in_if.sink       din,
	input  logic          q_full,
	output logic          push,
	output sled_pkg::ent_t push_ent
);
	import sled_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] delim_q, delim_d;
	logic [7:0] acc_q, acc_d;
	logic [1:0] skip_q, skip_d;
	logic [1:0] cnt;
	logic [1:0] skip_dec;
	logic [1:0] trail;
	logic       body;
	logic       accept;
	logic [7:0] b;
	logic [7:0] v;
	res_t       r0, r1;
	digit_t     dg;

	assign din.ready = !q_full;
	assign accept    = din.valid && din.ready;
	assign b         = din.in_byte;
	assign trail     = trail_count(b);
	assign dg        = digit_of(mode_q, b);
	assign skip_dec  = skip_q - 2'd1;

	always_comb begin
		mode_d  = mode_q;
		delim_d = delim_q;
		acc_d   = acc_q;
		skip_d  = skip_q;
		cnt     = 2'd0;
		r0      = '0;
		r1      = '0;
		body    = 1'b0;
		v       = b;
		if (din.source_end) begin
			if (mode_q == M_HEX || mode_q == M_DEC || mode_q == M_OCT) begin
				r0  = '{out_byte: acc_q, literal_done: 1'b0, unterminated: 1'b0};
				r1  = '{out_byte: 8'h00, literal_done: 1'b0, unterminated: 1'b1};
				cnt = 2'd2;
			end else if (mode_q != M_IDLE) begin
				r0  = '{out_byte: 8'h00, literal_done: 1'b0, unterminated: 1'b1};
				cnt = 2'd1;
			end
			mode_d = M_IDLE;
			skip_d = 2'd0;
		end else if (din.is_open) begin
			delim_d = b;
			acc_d   = 8'h00;
			skip_d  = 2'd0;
			mode_d  = M_BODY;
			r0      = '{out_byte: b, literal_done: 1'b0, unterminated: 1'b0};
			cnt     = 2'd1;
		end else begin
			unique case (mode_q)
				M_ESC: begin
					unique case (b)
						CH_N:    v = CTL_LF;
						CH_R:    v = CTL_CR;
						CH_T:    v = CTL_TAB;
						CH_V:    v = CTL_VT;
						CH_E:    v = CTL_ESC;
						CH_B:    v = CTL_BS;
						CH_ZERO: v = CTL_NUL;
						default: v = b;
					endcase
					if (b == CH_X || b == CH_D || b == CH_O) begin
						mode_d = (b == CH_X) ? M_HEX : ((b == CH_D) ? M_DEC : M_OCT);
						acc_d  = 8'h00;
					end else begin
						r0  = '{out_byte: v, literal_done: 1'b0, unterminated: 1'b0};
						cnt = 2'd1;
						if (trail != 2'd0) begin
							skip_d = trail;
							mode_d = M_SKIP;
						end else begin
							mode_d = M_BODY;
						end
					end
				end
				M_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 2'd0) mode_d = M_BODY;
				end
				M_PASS: begin
					r0     = '{out_byte: b, literal_done: 1'b0, unterminated: 1'b0};
					cnt    = 2'd1;
					skip_d = skip_dec;
					if (skip_dec == 2'd0) mode_d = M_BODY;
				end
				M_HEX, M_DEC, M_OCT: begin
					if (dg.ok) begin
						if (mode_q == M_HEX) begin
							acc_d = {acc_q[3:0], 4'h0} + {4'h0, dg.value};
						end else if (mode_q == M_DEC) begin
							acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0}
								+ {4'h0, dg.value};
						end else begin
							acc_d = {acc_q[4:0], 3'b000} + {4'h0, dg.value};
						end
					end else begin
						r0     = '{out_byte: acc_q, literal_done: 1'b0, unterminated: 1'b0};
						cnt    = 2'd1;
						mode_d = M_BODY;
						body   = 1'b1;
					end
				end
				M_BODY: body = 1'b1;
				default: ;
			endcase
			if (body) begin
				if (b == delim_q) begin
					if (cnt == 2'd0) r0 = '{out_byte: b, literal_done: 1'b1, unterminated: 1'b0};
					else r1 = '{out_byte: b, literal_done: 1'b1, unterminated: 1'b0};
					cnt    = cnt + 2'd1;
					mode_d = M_IDLE;
				end else if (b == CH_BSLASH) begin
					mode_d = M_ESC;
				end else begin
					if (cnt == 2'd0) r0 = '{out_byte: b, literal_done: 1'b0, unterminated: 1'b0};
					else r1 = '{out_byte: b, literal_done: 1'b0, unterminated: 1'b0};
					cnt = cnt + 2'd1;
					if (trail != 2'd0) begin
						skip_d = trail;
						mode_d = M_PASS;
					end
				end
			end
		end
	end

	assign push            = accept && (cnt != 2'd0);
	assign push_ent.two    = (cnt == 2'd2);
	assign push_ent.first  = r0;
	assign push_ent.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			delim_q <= 8'h00;
			acc_q   <= 8'h00;
			skip_q  <= 2'd0;
		end else if (accept) begin
			mode_q  <= mode_d;
			delim_q <= delim_d;
			acc_q   <= acc_d;
			skip_q  <= skip_d;
		end
	end

endmodule

// ----- src/sled_queue.sv -----
`timescale 1ns / 1ps
module sled_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sled_pkg::ent_t push_ent,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output sled_pkg::ent_t q_ent
);
	import sled_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ent_t          store_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_ent   = store_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// ----- src/sled_back.sv -----
`timescale 1ns / 1ps
module sled_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  sled_pkg::ent_t q_ent,
	output logic           pop,
	sled_out_if.source     dout
);
	import sled_pkg::*;

	ent_t ent_q;
	logic valid_q;
	logic second_q;
	logic last;
	logic advance;
	res_t cur;

	assign last    = !ent_q.two || second_q;
	assign cur     = second_q ? ent_q.second : ent_q.first;
	assign advance = !valid_q || (dout.ready && last);
	assign pop     = q_valid && advance;

	assign dout.valid        = valid_q;
	assign dout.out_byte     = cur.out_byte;
	assign dout.literal_done = cur.literal_done;
	assign dout.unterminated = cur.unterminated;
	assign dout.run_last     = last;

	always_ff @(posedge clk) begin
		if (pop) ent_q <= q_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (advance) begin
			valid_q  <= q_valid;
			second_q <= 1'b0;
		end else if (dout.ready) begin
			second_q <= 1'b1;
		end
	end

endmodule

// ----- src/string_literal_escape_decoder_top.sv -----
`timescale 1ns / 1ps
// Decodes a string literal one source byte per word: the opening delimiter is stored and
// echoed, escapes are turned into their byte values, and the closing delimiter or the end
// of the source closes the literal. The front end takes one input word every cycle while
// its queue of QUEUE_DEPTH entries has room; the back end hands out one result word per
// cycle while the receiver is ready, so an input that yields two results (a pending numeric
// escape closed by a byte other than a backslash, or by the end of the source) takes two
// output words, and a sustained run of such inputs fills the queue and holds back input.
module string_literal_escape_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	sled_in_if.sink    din,
	sled_out_if.source dout
);
	import sled_pkg::*;

	logic push, full, pop, q_valid;
	ent_t push_ent, q_ent;

	sled_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.q_full   (full),
		.push     (push),
		.push_ent (push_ent)
	);

	sled_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_ent    (q_ent)
	);

	sled_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ent   (q_ent),
		.pop     (pop),
		.dout    (dout)
	);

endmodule

// ----- sim/sled_decode_checker.sv -----
`timescale 1ns / 1ps
module sled_decode_checker (
	input  logic clk,
	input  logic arst_n,
	sled_in_if   din,
	sled_out_if  dout,
	output int   errors,
	output int   outstanding
);
	import sled_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       literal_done;
		logic       unterminated;
		logic       run_last;
	} text_word_t;

	text_word_t pending_text[$];
	mode_t      mode = M_IDLE;
	logic [7:0] delim = 8'h00;
	logic [7:0] acc = 8'h00;
	logic [1:0] skip_left = 2'd0;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic text_word_t text_word(input logic [7:0] b, input logic done,
			input logic unterm);
		text_word_t w;
		w.out_byte = b;
		w.literal_done = done;
		w.unterminated = unterm;
		w.run_last = 1'b0;
		return w;
	endfunction

	function automatic logic [1:0] follow_count(input logic [7:0] b);
		if (b >= 8'hC0 && b <= 8'hDF) return 2'd1;
		if (b >= 8'hE0 && b <= 8'hEF) return 2'd2;
		if (b >= 8'hF0 && b <= 8'hF7) return 2'd3;
		return 2'd0;
	endfunction

	function automatic int digit_in(input mode_t m, input logic [7:0] b);
		if (b >= CH_ZERO && b <= 8'h39) begin
			if (m == M_OCT && b > 8'h37) return -1;
			return int'(b) - int'(CH_ZERO);
		end
		if (m == M_HEX && b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
		if (m == M_HEX && b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
		return -1;
	endfunction

	task automatic decode_word(input logic [7:0] b, input logic start, input logic fin);
		text_word_t made[$];
		logic       as_body;
		logic [7:0] v;
		logic [1:0] trail;
		int         d;
		int         radix;
		as_body = 1'b0;
		if (fin) begin
			if (mode == M_HEX || mode == M_DEC || mode == M_OCT)
				made.push_back(text_word(acc, 1'b0, 1'b0));
			if (mode != M_IDLE)
				made.push_back(text_word(8'h00, 1'b0, 1'b1));
			mode = M_IDLE;
			skip_left = 2'd0;
		end else if (start) begin
			delim = b;
			acc = 8'h00;
			skip_left = 2'd0;
			mode = M_BODY;
			made.push_back(text_word(b, 1'b0, 1'b0));
		end else begin
			case (mode)
				M_ESC: begin
					if (b == CH_X || b == CH_D || b == CH_O) begin
						mode = (b == CH_X) ? M_HEX : (b == CH_D) ? M_DEC : M_OCT;
						acc = 8'h00;
					end else begin
						case (b)
							CH_N:    v = CTL_LF;
							CH_R:    v = CTL_CR;
							CH_T:    v = CTL_TAB;
							CH_V:    v = CTL_VT;
							CH_E:    v = CTL_ESC;
							CH_B:    v = CTL_BS;
							CH_ZERO: v = CTL_NUL;
							default: v = b;
						endcase
						made.push_back(text_word(v, 1'b0, 1'b0));
						trail = follow_count(b);
						if (trail != 2'd0) begin
							skip_left = trail;
							mode = M_SKIP;
						end else begin
							mode = M_BODY;
						end
					end
				end
				M_SKIP: begin
					skip_left = skip_left - 2'd1;
					if (skip_left == 2'd0) mode = M_BODY;
				end
				M_PASS: begin
					made.push_back(text_word(b, 1'b0, 1'b0));
					skip_left = skip_left - 2'd1;
					if (skip_left == 2'd0) mode = M_BODY;
				end
				M_HEX, M_DEC, M_OCT: begin
					d = digit_in(mode, b);
					if (d >= 0) begin
						radix = (mode == M_HEX) ? 16 : (mode == M_DEC) ? 10 : 8;
						acc = 8'((int'(acc) * radix + d) & 'hFF);
					end else begin
						made.push_back(text_word(acc, 1'b0, 1'b0));
						mode = M_BODY;
						as_body = 1'b1;
					end
				end
				M_BODY: begin
					as_body = 1'b1;
				end
				default: begin
				end
			endcase
			if (as_body) begin
				if (b == delim) begin
					made.push_back(text_word(b, 1'b1, 1'b0));
					mode = M_IDLE;
				end else if (b == CH_BSLASH) begin
					mode = M_ESC;
				end else begin
					made.push_back(text_word(b, 1'b0, 1'b0));
					trail = follow_count(b);
					if (trail != 2'd0) begin
						skip_left = trail;
						mode = M_PASS;
					end
				end
			end
		end
		if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
		foreach (made[i]) pending_text.push_back(made[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_word_t seen;
		text_word_t want;
		if (!arst_n) begin
			mode = M_IDLE;
			delim = 8'h00;
			acc = 8'h00;
			skip_left = 2'd0;
			pending_text.delete();
		end else begin
			if (dout.valid && dout.ready) begin
				seen.out_byte = dout.out_byte;
				seen.literal_done = dout.literal_done;
				seen.unterminated = dout.unterminated;
				seen.run_last = dout.run_last;
				if (pending_text.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected word: byte %h done %b unterm %b last %b",
							$realtime, seen.out_byte, seen.literal_done, seen.unterminated,
							seen.run_last);
				end else begin
					want = pending_text.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch: expected byte %h done %b unterm %b last %b,",
								$realtime, want.out_byte, want.literal_done,
								want.unterminated, want.run_last,
								" got byte %h done %b unterm %b last %b", seen.out_byte,
								seen.literal_done, seen.unterminated, seen.run_last);
					end
				end
			end
			if (din.valid && din.ready)
				decode_word(din.in_byte, din.is_open, din.source_end);
		end
		outstanding = pending_text.size();
	end

endmodule

// ----- sim/tb_string_literal_escape_decoder_top.sv -----
`timescale 1ns / 1ps
module tb_string_literal_escape_decoder_top;
	import sled_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam logic [7:0] QUOTE = 8'h22;
	localparam logic [7:0] APOS  = 8'h27;

	typedef struct packed {
		logic [7:0] b;
		logic       start;
		logic       fin;
	} src_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 18;
	int   recv_stall_pct = 46;
	int   literal_items = 0;
	int   cycle_count = 0;
	int   errors;
	int   outstanding;

	src_word_t words[$];

	sled_in_if  din();
	sled_out_if dout();

	string_literal_escape_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	sled_decode_checker decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.din         (din),
		.dout        (dout),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		dout.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic add_word(input logic [7:0] b, input logic start, input logic fin);
		src_word_t w;
		w.b = b;
		w.start = start;
		w.fin = fin;
		words.push_back(w);
	endtask

	task automatic put_word(input src_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.in_byte <= w.b;
		din.is_open <= w.start;
		din.source_end <= w.fin;
		do @(posedge clk); while (!din.ready);
		@(negedge clk);
	endtask

	task automatic send_words(input bit counted);
		foreach (words[i]) begin
			put_word(words[i]);
			if (counted) literal_items++;
		end
		words.delete();
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] digit_char(input int radix);
		int d;
		d = $urandom_range(radix - 1);
		if (d < 10) return CH_ZERO + 8'(d);
		return (($urandom_range(1) == 0) ? 8'h61 : 8'h41) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] lead_byte(input int trail);
		if (trail == 1) return 8'hC0 + 8'($urandom_range(31));
		if (trail == 2) return 8'hE0 + 8'($urandom_range(15));
		return 8'hF0 + 8'($urandom_range(7));
	endfunction

	task automatic build_literal();
		logic [7:0] delim;
		logic [7:0] b;
		int         r;
		int         kind;
		int         n;
		int         radix;
		r = $urandom_range(99);
		delim = (r < 55) ? QUOTE : (r < 70) ? APOS : (r < 75) ? CH_BSLASH :
			8'($urandom_range(255));
		add_word(delim, 1'b1, 1'b0);
		repeat ($urandom_range(8)) begin
			kind = $urandom_range(9);
			if (delim == CH_BSLASH && kind >= 3 && kind <= 7) kind = 0;
			case (kind)
				0, 1, 2: begin
					b = 8'($urandom_range(255));
					if (b == delim || b == CH_BSLASH) b = b ^ 8'h01;
					add_word(b, 1'b0, 1'b0);
				end
				3, 4: begin
					add_word(CH_BSLASH, 1'b0, 1'b0);
					case ($urandom_range(9))
						0: b = CH_N;
						1: b = CH_R;
						2: b = CH_T;
						3: b = CH_V;
						4: b = CH_E;
						5: b = CH_B;
						6: b = CH_ZERO;
						7: b = CH_BSLASH;
						8: b = delim;
						default: b = 8'($urandom_range(255));
					endcase
					add_word(b, 1'b0, 1'b0);
				end
				5, 6: begin
					r = $urandom_range(2);
					radix = (r == 0) ? 16 : (r == 1) ? 10 : 8;
					add_word(CH_BSLASH, 1'b0, 1'b0);
					add_word((r == 0) ? CH_X : (r == 1) ? CH_D : CH_O, 1'b0, 1'b0);
					repeat ($urandom_range(4)) add_word(digit_char(radix), 1'b0, 1'b0);
				end
				7: begin
					n = $urandom_range(1, 3);
					add_word(CH_BSLASH, 1'b0, 1'b0);
					add_word(lead_byte(n), 1'b0, 1'b0);
					repeat (n) add_word(8'h80 + 8'($urandom_range(63)), 1'b0, 1'b0);
				end
				8: begin
					n = $urandom_range(1, 3);
					add_word(lead_byte(n), 1'b0, 1'b0);
					repeat (n) begin
						b = ($urandom_range(3) == 0) ? delim : 8'h80 + 8'($urandom_range(63));
						add_word(b, 1'b0, 1'b0);
					end
				end
				default: begin
					add_word(8'($urandom_range(255)), 1'b0, 1'b0);
				end
			endcase
		end
		r = $urandom_range(99);
		if (r < 75)
			add_word(delim, 1'b0, 1'b0);
		else if (r < 92)
			add_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
	endtask

	task automatic build_noise();
		case ($urandom_range(2))
			0: add_word(8'($urandom_range(255)), 1'b0, 1'b0);
			1: add_word(8'($urandom_range(255)), 1'b0, 1'b1);
			default: add_word(8'($urandom_range(255)), 1'b1, 1'b1);
		endcase
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int target);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (literal_items < target) begin
			if ($urandom_range(9) == 0) begin
				build_noise();
				send_words(1'b0);
			end
			build_literal();
			send_words(1'b1);
		end
		drain();
	endtask

	initial begin
		din.valid = 1'b0;
		din.in_byte = 8'h00;
		din.is_open = 1'b0;
		din.source_end = 1'b0;
		dout.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_word(8'hA5, 1'b0, 1'b0);
		add_word(8'h00, 1'b0, 1'b1);
		add_word(QUOTE, 1'b1, 1'b1);
		add_word(QUOTE, 1'b1, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(CH_X, 1'b0, 1'b0);
		add_word(8'h46, 1'b0, 1'b0);
		add_word(8'h66, 1'b0, 1'b0);
		add_word(8'h31, 1'b0, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(CH_E, 1'b0, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(8'hE2, 1'b0, 1'b0);
		add_word(8'h82, 1'b0, 1'b0);
		add_word(8'hAC, 1'b0, 1'b0);
		add_word(8'hC3, 1'b0, 1'b0);
		add_word(QUOTE, 1'b0, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(CH_D, 1'b0, 1'b0);
		add_word(8'h39, 1'b0, 1'b0);
		add_word(8'h39, 1'b0, 1'b0);
		add_word(8'h39, 1'b0, 1'b0);
		add_word(QUOTE, 1'b0, 1'b0);
		add_word(CH_BSLASH, 1'b1, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(APOS, 1'b1, 1'b0);
		add_word(CH_BSLASH, 1'b0, 1'b0);
		add_word(CH_O, 1'b0, 1'b0);
		add_word(8'h37, 1'b0, 1'b0);
		add_word(8'hFF, 1'b1, 1'b0);
		add_word(8'h00, 1'b0, 1'b1);
		send_words(1'b0);
		drain();

		run_phase(18, 46, 150);
		run_phase(46, 18, 300);
		run_phase(0, 0, 450);

		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
